### rtl/core/bvrp_pkg.sv
// Shared widths, codes, word types and helper function of the vertex range partitioner.
// Used by the channel interfaces and by every module in rtl/core.
`default_nettype none
package bvrp_pkg;

	localparam int VERTEX_ID_BITS = 24;
	localparam int SET_INDEX_BITS = 17;

	localparam int VC_BITS     = VERTEX_ID_BITS + 1;
	localparam int WEIGHT_BITS = 32;
	localparam int EDGE_BITS   = 32;
	localparam int TS_BITS     = SET_INDEX_BITS;
	localparam int KS_BITS     = SET_INDEX_BITS + 1;
	localparam int VL_BITS     = VERTEX_ID_BITS + 3;
	localparam int STATUS_BITS = 2;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;

	localparam int SCALE = 10000;
	localparam longint unsigned KLIMIT = longint'(SCALE) << SET_INDEX_BITS;
	localparam int K_BITS    = $clog2(KLIMIT);
	localparam int PROD_BITS = WEIGHT_BITS + K_BITS + 1;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
	localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

	localparam logic [STATUS_BITS-1:0] STATUS_OK           = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_DECREASING   = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_OUT_OF_RANGE = 2'd2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_VERTEX_COUNT = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_SETS  = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TOTAL_EDGES  = 2'd2;

	typedef logic [VERTEX_ID_BITS-1:0] vertex_t;
	typedef logic [WEIGHT_BITS-1:0]    weight_t;
	typedef logic [SET_INDEX_BITS-1:0] set_t;
	typedef logic [K_BITS-1:0]         kcoef_t;

	typedef struct packed {
		vertex_t                range_first;
		vertex_t                range_last;
		set_t                   set_index;
		logic [STATUS_BITS-1:0] status;
		logic                   last_of_run;
	} range_word_t;

	typedef struct packed {
		logic [1:0]  count;
		range_word_t first;
		range_word_t second;
	} push_t;

	typedef struct packed {
		weight_t              cur_weight;
		weight_t              rng_weight;
		vertex_t              width;
		logic [EDGE_BITS-1:0] edges_left;
		logic [VL_BITS-1:0]   verts_left;
		kcoef_t               kcoef;
		logic                 kneg;
	} close_in_t;

	function automatic kcoef_t kcoef_of(input logic [KS_BITS-1:0] k);
		logic [63:0] wide;
		wide = 64'(k) * 64'(SCALE) + 64'd1;
		return K_BITS'(wide);
	endfunction

endpackage
`default_nettype wire

### rtl/core/bvrp_ifs.sv
// Valid/ready channel interfaces of the vertex range partitioner: edges in, ranges out, config.
// Depends on bvrp_pkg for field widths.
`default_nettype none
interface bvrp_edge_if;
	import bvrp_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [VERTEX_ID_BITS-1:0] source_vertex;
	logic                      end_of_edges;
	modport source (output valid, source_vertex, end_of_edges, input ready);
	modport sink (input valid, source_vertex, end_of_edges, output ready);
endinterface

interface bvrp_range_if;
	import bvrp_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [VERTEX_ID_BITS-1:0] range_first;
	logic [VERTEX_ID_BITS-1:0] range_last;
	logic [SET_INDEX_BITS-1:0] set_index;
	logic [STATUS_BITS-1:0]    status;
	logic                      last_of_run;
	modport source (output valid, range_first, range_last, set_index, status, last_of_run,
		input ready);
	modport sink (input valid, range_first, range_last, set_index, status, last_of_run,
		output ready);
endinterface

interface bvrp_cfg_if;
	import bvrp_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/core/bvrp_close_test.sv
// Range close decision: scaled weight and width products against scaled remaining counts.
// Depends on bvrp_pkg.
`default_nettype none
module bvrp_close_test (
	input  bvrp_pkg::close_in_t terms,
	output logic                close
);
	import bvrp_pkg::*;

	logic [PROD_BITS-1:0] pcw, prw, pd, psum, pd1, t1w, t1m;
	logic                 nm_neg;
	logic                 c_cur, c_rng, c_wid, c_sum, c_wid1;

	assign pcw  = PROD_BITS'(terms.cur_weight) * PROD_BITS'(terms.kcoef);
	assign prw  = PROD_BITS'(terms.rng_weight) * PROD_BITS'(terms.kcoef);
	assign pd   = PROD_BITS'(terms.width) * PROD_BITS'(terms.kcoef);
	assign psum = pcw + prw;
	assign pd1  = pd + PROD_BITS'(terms.kcoef);

	assign t1w    = PROD_BITS'(terms.edges_left) * PROD_BITS'(SCALE);
	assign t1m    = PROD_BITS'(terms.verts_left[VL_BITS-2:0]) * PROD_BITS'(SCALE);
	// a negative vertex count left disables the width tests, as if no width product reached its threshold
	assign nm_neg = terms.verts_left[VL_BITS-1];

	assign c_cur  = pcw >= (t1w << 1);
	assign c_rng  = prw >= t1w;
	assign c_sum  = psum >= (t1w << 1);
	assign c_wid  = !nm_neg && (pd >= t1m);
	assign c_wid1 = !nm_neg && (pd1 >= (t1m << 1));

	assign close = terms.kneg || c_cur || c_rng || c_wid || c_sum || c_wid1;

endmodule
`default_nettype wire

### rtl/core/bvrp_result_fifo.sv
// Four-entry result queue taking up to two range words per cycle, draining one per cycle while ranges.ready is high.
// Depends on bvrp_pkg and bvrp_range_if.
`default_nettype none
module bvrp_result_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bvrp_pkg::push_t        push,
	output logic                   room2,
	bvrp_range_if.source           ranges
);
	import bvrp_pkg::*;

	range_word_t             mem_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0]     count_q;
	logic                    pop;
	range_word_t             head;

	assign pop   = ranges.valid && ranges.ready;
	assign room2 = count_q <= CNT_BITS'(FIFO_DEPTH - 2);
	assign head  = mem_q[rd_ptr_q];

	assign ranges.valid       = count_q != '0;
	assign ranges.range_first = head.range_first;
	assign ranges.range_last  = head.range_last;
	assign ranges.set_index   = head.set_index;
	assign ranges.status      = head.status;
	assign ranges.last_of_run = head.last_of_run;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + PTR_BITS'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_BITS'(push.count);
			rd_ptr_q <= rd_ptr_q + PTR_BITS'(pop);
			count_q  <= count_q + CNT_BITS'(push.count) - CNT_BITS'(pop);
		end
	end

endmodule
`default_nettype wire

### rtl/core/balanced_vertex_range_partitioner_unit.sv
// Top level of the vertex range partitioner: input register, range state, close test, result queue.
// Depends on bvrp_pkg, bvrp_ifs, bvrp_close_test and bvrp_result_fifo.
//
// Streams the source vertex of each edge of a source-sorted list, one edge per cycle, and emits
// the contiguous vertex ranges it closes; the edge marked end_of_edges also emits the final range
// and restarts the stream state. An edge is held in an input register, where the
// close test (two 32x31 and one 24x31 multiply against scaled remaining counts) decides its
// results; a range that an edge closes is written from there into the queue. Results go
// through a four-entry queue: the input stalls only while fewer than two places are free. A
// decreasing id or an id above vertex_count yields one error word and halts the block until
// reset. Config writes are always taken and should only be made while no edge is in flight.
`default_nettype none
module balanced_vertex_range_partitioner_unit (
	input  logic           clk,
	input  logic           arst_n,
	bvrp_cfg_if.sink       cfg,
	bvrp_edge_if.sink      edges,
	bvrp_range_if.source   ranges
);
	import bvrp_pkg::*;

	logic                   valid_s1;
	vertex_t                sv_s1;
	logic                   end_s1;

	logic [VC_BITS-1:0]     vc_q;
	logic [TS_BITS-1:0]     ts_q;
	logic [EDGE_BITS-1:0]   te_q;

	vertex_t                rs_q, cv_q;
	weight_t                rw_q, cw_q;
	set_t                   rc_q;
	logic [EDGE_BITS-1:0]   es_q, nw_q;
	logic [VL_BITS-1:0]     nm_q;
	logic [KS_BITS-1:0]     k_q;
	kcoef_t                 kcoef_q;
	logic                   halted_q;

	logic                   room2, fire, accept;
	logic                   err_dec, err_rng, newv, close, close_hit, rc_inc;
	logic [EDGE_BITS-1:0]   es_inc, nw_close;
	weight_t                cw_inc;
	vertex_t                rs_c, cv_c;
	set_t                   rc_c;
	logic [VL_BITS-1:0]     nm_close;
	logic [KS_BITS-1:0]     k_cfg;
	close_in_t              terms;
	range_word_t            close_word, final_word, err_word;
	push_t                  push;

	assign fire   = valid_s1 && room2;
	assign accept = edges.valid && edges.ready;
	assign edges.ready = !valid_s1 || fire;
	assign cfg.ready   = 1'b1;

	assign terms.cur_weight = cw_q;
	assign terms.rng_weight = rw_q;
	assign terms.width      = cv_q - rs_q;
	assign terms.edges_left = nw_q;
	assign terms.verts_left = nm_q;
	assign terms.kcoef      = kcoef_q;
	assign terms.kneg       = k_q[KS_BITS-1];

	bvrp_close_test u_close (
		.terms (terms),
		.close (close)
	);

	always_comb begin
		err_dec   = sv_s1 < cv_q;
		err_rng   = VC_BITS'(sv_s1) > vc_q;
		newv      = sv_s1 > cv_q;
		close_hit = newv && close;
		rc_inc    = rc_q != '1;
		es_inc    = (es_q != '1) ? es_q + EDGE_BITS'(1) : es_q;
		cw_inc    = (cw_q != '1) ? cw_q + WEIGHT_BITS'(1) : cw_q;
		nw_close  = (te_q > es_inc) ? te_q - es_inc : '0;
		nm_close  = VL_BITS'(vc_q) - VL_BITS'(cv_q) + VL_BITS'(1);
		k_cfg     = KS_BITS'(cfg.data[TS_BITS-1:0]) - KS_BITS'(rc_q);
		rs_c      = close_hit ? cv_q : rs_q;
		rc_c      = (close_hit && rc_inc) ? rc_q + SET_INDEX_BITS'(1) : rc_q;
		cv_c      = newv ? sv_s1 : cv_q;

		close_word = '{range_first: rs_q, range_last: cv_q, set_index: rc_q,
			status: STATUS_OK, last_of_run: !end_s1};
		final_word = '{range_first: rs_c, range_last: cv_c, set_index: rc_c,
			status: STATUS_OK, last_of_run: 1'b1};
		err_word   = '{range_first: '0, range_last: '0, set_index: '0,
			status: err_dec ? STATUS_DECREASING : STATUS_OUT_OF_RANGE, last_of_run: 1'b1};

		push.first  = close_word;
		push.second = final_word;
		push.count  = 2'd0;
		priority if (!fire || halted_q) begin
			push.count = 2'd0;
		end else if (err_dec || err_rng) begin
			push.first = err_word;
			push.count = 2'd1;
		end else if (close_hit) begin
			push.count = end_s1 ? 2'd2 : 2'd1;
		end else if (end_s1) begin
			push.first = final_word;
			push.count = 2'd1;
		end else begin
			push.count = 2'd0;
		end
	end

	bvrp_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room2  (room2),
		.ranges (ranges)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			sv_s1  <= edges.source_vertex;
			end_s1 <= edges.end_of_edges;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			vc_q     <= VC_BITS'(1) << VERTEX_ID_BITS;
			ts_q     <= TS_BITS'(1);
			te_q     <= '0;
			rs_q     <= '0;
			rw_q     <= '0;
			cv_q     <= '0;
			cw_q     <= '0;
			rc_q     <= '0;
			es_q     <= '0;
			nm_q     <= VL_BITS'(1) << VERTEX_ID_BITS;
			nw_q     <= '0;
			k_q      <= KS_BITS'(1);
			kcoef_q  <= K_BITS'(SCALE + 1);
			halted_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end

			if (fire && !halted_q) begin
				if (err_dec || err_rng) begin
					halted_q <= 1'b1;
				end else if (end_s1) begin
					rs_q    <= '0;
					rw_q    <= '0;
					cv_q    <= '0;
					cw_q    <= '0;
					rc_q    <= '0;
					es_q    <= '0;
					nm_q    <= VL_BITS'(vc_q);
					nw_q    <= te_q;
					k_q     <= KS_BITS'(ts_q);
					kcoef_q <= kcoef_of(KS_BITS'(ts_q));
				end else begin
					es_q <= es_inc;
					if (close_hit) begin
						rs_q <= cv_q;
						rw_q <= cw_q;
						nm_q <= nm_close;
						nw_q <= nw_close;
						if (rc_inc) begin
							rc_q    <= rc_q + SET_INDEX_BITS'(1);
							k_q     <= k_q - KS_BITS'(1);
							kcoef_q <= kcoef_q - K_BITS'(SCALE);
						end
					end
					if (newv) begin
						cv_q <= sv_s1;
						cw_q <= WEIGHT_BITS'(1);
					end else begin
						cw_q <= cw_inc;
					end
				end
			end

			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_VERTEX_COUNT: begin
						vc_q <= cfg.data[VC_BITS-1:0];
						if (rc_q == '0) begin
							nm_q <= VL_BITS'(cfg.data[VC_BITS-1:0]);
						end
					end
					REG_TARGET_SETS: begin
						ts_q    <= cfg.data[TS_BITS-1:0];
						k_q     <= k_cfg;
						kcoef_q <= kcoef_of(k_cfg);
					end
					REG_TOTAL_EDGES: begin
						te_q <= cfg.data[EDGE_BITS-1:0];
						if (rc_q == '0) begin
							nw_q <= cfg.data[EDGE_BITS-1:0];
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

### tb/sv/bvrp_range_checker.sv
// Range checker of the vertex range partitioner: watches the config, edge and range channels,
// predicts each range word from its own copy of the registers and stream state, and compares.
// Depends on bvrp_pkg and the channel interfaces of bvrp_ifs.
`default_nettype none
module bvrp_range_checker (
	input  logic   clk,
	input  logic   arst_n,
	bvrp_cfg_if    cfg,
	bvrp_edge_if   edges,
	bvrp_range_if  ranges,
	output int     pending,
	output int     mismatches
);
	timeunit 1ns;
	timeprecision 1ps;
	import bvrp_pkg::*;

	localparam logic [63:0]        SHARE_SCALE        = 64'd10000;
	localparam logic [VC_BITS-1:0] VERTEX_COUNT_RESET = VC_BITS'(1) << VERTEX_ID_BITS;

	logic [VC_BITS-1:0]   vcount;
	logic [TS_BITS-1:0]   tsets;
	logic [EDGE_BITS-1:0] tedges;

	vertex_t              rng_first;
	weight_t              rng_weight;
	vertex_t              cur_vertex;
	weight_t              cur_weight;
	set_t                 closed_cnt;
	logic [EDGE_BITS-1:0] seen_cnt;
	logic [63:0]          verts_left;
	logic [EDGE_BITS-1:0] edges_left;
	bit                   halted;

	range_word_t expected_q[$];
	int          bad = 0;

	// x >= mult * n / (k + 0.0001), scaled to integers
	function automatic bit reaches_share(input logic [63:0] x, input logic [63:0] n,
		input logic [63:0] mult, input longint k);
		if (k < 0)
			return 1'b1;
		return x * (64'(k) * SHARE_SCALE + 64'd1) >= mult * SHARE_SCALE * n;
	endfunction

	function automatic int field_differs(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want === got)
			return 0;
		$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
		return 1;
	endfunction

	task automatic restart_stream();
		rng_first  = '0;
		rng_weight = '0;
		cur_vertex = '0;
		cur_weight = '0;
		closed_cnt = '0;
		seen_cnt   = '0;
		verts_left = 64'(vcount);
		edges_left = tedges;
		halted     = 1'b0;
	endtask

	task automatic take_edge(input vertex_t id, input logic final_edge);
		range_word_t word;
		longint      k;
		logic [63:0] width;
		logic [63:0] nw;
		logic [63:0] nm;
		bit          shut;
		if (halted)
			return;
		if (id < cur_vertex || {1'b0, id} > vcount) begin
			word = '0;
			word.status = (id < cur_vertex) ? STATUS_DECREASING : STATUS_OUT_OF_RANGE;
			word.last_of_run = 1'b1;
			expected_q = {expected_q, word};
			halted = 1'b1;
			return;
		end
		if (seen_cnt != '1)
			seen_cnt++;
		if (id > cur_vertex) begin
			k = longint'(tsets) - longint'(closed_cnt);
			width = 64'(cur_vertex - rng_first);
			nw = 64'(edges_left);
			nm = verts_left;
			shut = reaches_share(64'(cur_weight), nw, 64'd2, k)
				|| reaches_share(64'(rng_weight), nw, 64'd1, k)
				|| reaches_share(width, nm, 64'd1, k)
				|| reaches_share(64'(rng_weight) + 64'(cur_weight), nw, 64'd2, k)
				|| reaches_share(width + 64'd1, nm, 64'd2, k);
			if (shut) begin
				word = '0;
				word.range_first = rng_first;
				word.range_last = cur_vertex;
				word.set_index = closed_cnt;
				word.status = STATUS_OK;
				word.last_of_run = !final_edge;
				expected_q = {expected_q, word};
				if (closed_cnt != '1)
					closed_cnt++;
				rng_first = cur_vertex;
				rng_weight = cur_weight;
				verts_left = 64'(vcount) - 64'(cur_vertex) + 64'd1;
				edges_left = (tedges > seen_cnt) ? tedges - seen_cnt : '0;
			end
			cur_vertex = id;
			cur_weight = WEIGHT_BITS'(1);
		end else if (cur_weight != '1) begin
			cur_weight++;
		end
		if (final_edge) begin
			word = '0;
			word.range_first = rng_first;
			word.range_last = cur_vertex;
			word.set_index = closed_cnt;
			word.status = STATUS_OK;
			word.last_of_run = 1'b1;
			expected_q = {expected_q, word};
			restart_stream();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		range_word_t want;
		if (!arst_n) begin
			vcount = VERTEX_COUNT_RESET;
			tsets  = TS_BITS'(1);
			tedges = '0;
			restart_stream();
			expected_q.delete();
			pending <= 0;
			mismatches <= bad;
		end else begin
			if (ranges.valid && ranges.ready) begin
				if (expected_q.size() == 0) begin
					$error("range word with none expected: first 0x%0h last 0x%0h set %0d status %0d",
						ranges.range_first, ranges.range_last, ranges.set_index, ranges.status);
					bad++;
				end else begin
					want = expected_q.pop_front();
					bad += field_differs("range_first", 32'(want.range_first),
						32'(ranges.range_first));
					bad += field_differs("range_last", 32'(want.range_last),
						32'(ranges.range_last));
					bad += field_differs("set_index", 32'(want.set_index),
						32'(ranges.set_index));
					bad += field_differs("status", 32'(want.status), 32'(ranges.status));
					bad += field_differs("last_of_run", 32'(want.last_of_run),
						32'(ranges.last_of_run));
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_VERTEX_COUNT: begin
						vcount = cfg.data[VC_BITS-1:0];
						if (closed_cnt == '0)
							verts_left = 64'(vcount);
					end
					REG_TARGET_SETS: tsets = cfg.data[TS_BITS-1:0];
					REG_TOTAL_EDGES: begin
						tedges = cfg.data;
						if (closed_cnt == '0)
							edges_left = tedges;
					end
					default: ;
				endcase
			end
			if (edges.valid && edges.ready)
				take_edge(edges.source_vertex, edges.end_of_edges);
			pending <= expected_q.size();
			mismatches <= bad;
		end
	end

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Top of the vertex range partitioner testbench: clock, reset, edge and config stimulus,
// range receiver with stalls, and the verdict. Depends on bvrp_pkg, bvrp_ifs, the
// partitioner RTL and bvrp_range_checker.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import bvrp_pkg::*;

	localparam int unsigned VERTEX_SPAN   = 1 << VERTEX_ID_BITS;
	localparam int          EDGE_TARGET   = 1900;
	localparam int          CYCLE_LIMIT   = 400000;
	localparam int          SETTLE_CYCLES = 6;
	localparam int          HOLD_CYCLES   = 400;

	typedef enum int {SINK_OPEN, SINK_PATTERN, SINK_SPARSE} sink_mode_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int          pending_words;
	int          mismatch_count;
	int          cycle_count = 0;
	int          edges_sent = 0;
	int          burst_left = 0;
	bit          hold_request = 1'b0;
	bit          stream_open = 1'b0;
	vertex_t     stream_last = '0;
	int unsigned vc_now = VERTEX_SPAN;

	bvrp_cfg_if   cfg_ch ();
	bvrp_edge_if  edge_ch ();
	bvrp_range_if range_ch ();

	balanced_vertex_range_partitioner_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.edges  (edge_ch),
		.ranges (range_ch)
	);

	bvrp_range_checker range_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_ch),
		.edges      (edge_ch),
		.ranges     (range_ch),
		.pending    (pending_words),
		.mismatches (mismatch_count)
	);

	always begin
		#4ns clk = 1'b1;
		#4ns clk = 1'b0;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic configure(input int unsigned vc, input int unsigned ts,
		input logic [31:0] te, input logic [2:0] pick);
		if (pick[REG_VERTEX_COUNT]) begin
			write_reg(REG_VERTEX_COUNT, vc);
			vc_now = vc;
		end
		if (pick[REG_TARGET_SETS])
			write_reg(REG_TARGET_SETS, ts);
		if (pick[REG_TOTAL_EDGES])
			write_reg(REG_TOTAL_EDGES, te);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic push_edge(input vertex_t id, input logic final_edge);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(40, 160);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(1, 6);
			end
			if (gap > 0) begin
				edge_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		edge_ch.valid <= 1'b1;
		edge_ch.source_vertex <= id;
		edge_ch.end_of_edges <= final_edge;
		do @(posedge clk); while (!edge_ch.ready);
		burst_left--;
		edges_sent++;
		stream_open = !final_edge;
		stream_last = final_edge ? '0 : id;
	endtask

	// drop valid, drain all expected words, then let the input register empty
	task automatic settle();
		edge_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_list(input int n, input bit close_it, input bit spread);
		vertex_t     id;
		vertex_t     top_id;
		int unsigned step;
		int          r;
		top_id = (vc_now > VERTEX_SPAN - 1) ? vertex_t'(VERTEX_SPAN - 1) : vertex_t'(vc_now);
		if (stream_open)
			id = stream_last;
		else if (spread)
			id = vertex_t'($urandom_range(0, top_id));
		else
			id = vertex_t'($urandom_range(0, (top_id < 20) ? top_id : 20));
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				step = 0;
			else if (r < 80)
				step = $urandom_range(1, 3);
			else if (r < 95)
				step = $urandom_range(4, 64);
			else
				step = $urandom_range(65, 1 << 20);
			if (i > 0 || stream_open)
				id = (32'(id) + step > 32'(top_id)) ? top_id : vertex_t'(32'(id) + step);
			push_edge(id, close_it && i == n - 1);
		end
	endtask

	task automatic random_phase();
		int unsigned vc;
		int unsigned ts;
		int unsigned n;
		int unsigned vc_floor;
		logic [31:0] te;
		int          r;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(61, 160) : $urandom_range(1, 60);
		r = $urandom_range(0, 99);
		if (r < 30)
			vc = VERTEX_SPAN;
		else if (r < 45)
			vc = $urandom_range(1, 64);
		else
			vc = $urandom_range(1, VERTEX_SPAN);
		vc_floor = stream_open ? stream_last : 0;
		if (vc < vc_floor)
			vc = vc_floor;
		r = $urandom_range(0, 99);
		if (r < 50)
			ts = $urandom_range(1, 8);
		else if (r < 75)
			ts = $urandom_range(9, 64);
		else if (r < 85)
			ts = 65536;
		else
			ts = $urandom_range(1, 65536);
		r = $urandom_range(0, 99);
		if (r < 55)
			te = n + $urandom_range(0, 3);
		else if (r < 65)
			te = '0;
		else if (r < 75)
			te = '1;
		else
			te = $urandom_range(0, 4 * n);
		configure(vc, ts, te, 3'($urandom));
		send_list(n, $urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0);
		settle();
	endtask

	initial begin
		sink_mode_e  mode;
		int          seg_left;
		int          tick;
		logic [15:0] pat;
		range_ch.ready <= 1'b0;
		mode = SINK_OPEN;
		seg_left = 0;
		tick = 0;
		pat = '1;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				range_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(20, 200);
					mode = sink_mode_e'($urandom_range(0, 2));
					pat = 16'($urandom) | 16'h1111;
				end
				seg_left--;
				tick++;
				case (mode)
					SINK_OPEN:    range_ch.ready <= 1'b1;
					SINK_PATTERN: range_ch.ready <= pat[tick % 16];
					default:      range_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		vertex_t ramp[14] = '{0, 0, 0, 0, 1, 2, 3, 3, 10, 20, 21, 30, 40, 40};
		vertex_t bad_id;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_VERTEX_COUNT;
		cfg_ch.data <= '0;
		edge_ch.valid <= 1'b0;
		edge_ch.source_vertex <= '0;
		edge_ch.end_of_edges <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// register reset values, a close and the end on the same edge, largest id
		push_edge(0, 1'b0);
		push_edge(0, 1'b0);
		push_edge(7, 1'b0);
		push_edge(7, 1'b0);
		push_edge(7, 1'b0);
		push_edge('1, 1'b1);
		settle();

		configure(1, 65536, 32'hFFFF_FFFF, '1);
		push_edge(0, 1'b0);
		push_edge(1, 1'b0);
		push_edge(1, 1'b1);
		settle();

		configure(40, 3, 14, '1);
		foreach (ramp[i])
			push_edge(ramp[i], i == 13);
		settle();

		// fill the result queue while the receiver holds off
		configure(VERTEX_SPAN, 1, 0, '1);
		hold_request = 1'b1;
		for (int v = 1; v <= 150; v++)
			push_edge(vertex_t'(v), v == 150);
		settle();

		while (edges_sent < EDGE_TARGET)
			random_phase();

		// one error word, then edges the halted block must ignore
		if (stream_open) begin
			push_edge(stream_last, 1'b1);
			settle();
		end
		configure($urandom_range(100, 1000), 4, 40, '1);
		push_edge(10, 1'b0);
		push_edge(50, 1'b0);
		if ($urandom_range(0, 1) == 0)
			bad_id = vertex_t'($urandom_range(0, 49));
		else
			bad_id = vertex_t'(vc_now + $urandom_range(1, 1000));
		push_edge(bad_id, 1'($urandom));
		repeat (6) push_edge(vertex_t'($urandom), 1'($urandom));
		settle();
		repeat (20) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
`default_nettype wire
